### hdl/rmi_pkg.sv
// shared constants and control types for the residue modular inverse block
package rmi_pkg;

	localparam int NUM_MODULI = 4;
	localparam int VAL_W      = 62;
	localparam int COEF_W     = 64;
	localparam int SHIFT_W    = 6;
	localparam int IDX_W      = 2;
	localparam int DATA_W     = 64;

	// datapath commands from the controller
	typedef struct packed {
		logic load;
		logic check;
		logic align;
		logic sub;
		logic swap;
	} rmi_cmd_t;

	// datapath status back to the controller
	typedef struct packed {
		logic r1_zero;
		logic align_more;
		logic k_zero;
	} rmi_stat_t;

endpackage

### hdl/residue_modular_inverse.sv
// Modular inverse of one residue under one of up to four configured prime moduli.
// Input words: s_axis_tdata carries the residue, s_axis_tuser selects the modulus
// register; an index at or beyond the number of moduli falls back to modulus 0.
// Output words: m_axis_tdata carries the inverse, m_axis_tuser flags a zero residue
// (inverse forced to 0). Exactly one output word per input word, in order.
// Moduli are written through wr_en / wr_index / wr_data while the block is idle.
// Latency is data dependent and set by the extended euclidean loop, which runs on
// one shift-subtract unit: a load, then per division step a check, an align phase
// that doubles the divisor k times, a subtract phase that shifts it back and
// subtracts where it fits, and a swap, where k is floor(log2) of that step's
// quotient (0 for a zero quotient); then a last check and a finish state.
// One word is in flight; a new word is taken as soon as the previous result has
// moved into the output register. A stalled receiver holds that register, and the
// block stalls in its finish cycle until the register frees up.
// Reset clears the output valid flag and sets all moduli to 2.
module residue_modular_inverse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [rmi_pkg::DATA_W-1:0]    s_axis_tdata,  // residue[61:0]
	input  logic [rmi_pkg::IDX_W-1:0]     s_axis_tuser,  // modulus_index[1:0]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rmi_pkg::DATA_W-1:0]    m_axis_tdata,  // inverse[61:0]
	output logic                          m_axis_tuser,  // not_invertible
	input  logic                          wr_en,
	input  logic [rmi_pkg::IDX_W-1:0]     wr_index,
	input  logic [rmi_pkg::VAL_W-1:0]     wr_data
);

	logic [rmi_pkg::VAL_W-1:0] modulus_q [rmi_pkg::NUM_MODULI];
	logic [rmi_pkg::VAL_W-1:0] mod_sel;
	logic [rmi_pkg::VAL_W-1:0] inv_q;
	logic                      flag_q;
	logic                      valid_q;

	rmi_pkg::rmi_cmd_t         cmd;
	rmi_pkg::rmi_stat_t        stat;
	logic                      out_free;
	logic                      out_load;
	logic [rmi_pkg::VAL_W-1:0] dp_inverse;
	logic                      dp_flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rmi_pkg::NUM_MODULI; i++) begin
				modulus_q[i] <= rmi_pkg::VAL_W'(2);
			end
		end else if (wr_en && (int'(wr_index) < rmi_pkg::NUM_MODULI)) begin
			modulus_q[wr_index] <= wr_data;
		end
	end

	assign mod_sel = (int'(s_axis_tuser) < rmi_pkg::NUM_MODULI) ?
		modulus_q[s_axis_tuser] : modulus_q[0];

	rmi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (s_axis_tready),
		.out_load (out_load)
	);

	rmi_datapath u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.residue        (s_axis_tdata[rmi_pkg::VAL_W-1:0]),
		.modulus        (mod_sel),
		.stat           (stat),
		.inverse        (dp_inverse),
		.not_invertible (dp_flag)
	);

	// output register
	assign out_free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			inv_q  <= dp_inverse;
			flag_q <= dp_flag;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(rmi_pkg::DATA_W-rmi_pkg::VAL_W){1'b0}}, inv_q};
	assign m_axis_tuser  = flag_q;

`ifndef SYNTHESIS
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("flagged result with nonzero inverse");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again while a word is in work");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free && !s_axis_tready)
		else $error("output register loaded while occupied or idle");
`endif

endmodule

### hdl/rmi_ctrl.sv
// controller state machine sequencing the euclidean division steps
module rmi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_free,
	input  rmi_pkg::rmi_stat_t stat,
	output rmi_pkg::rmi_cmd_t  cmd,
	output logic              in_ready,
	output logic              out_load
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_ALIGN  = 6'b000100,
		ST_SUB    = 6'b001000,
		ST_SWAP   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (stat.r1_zero) begin
					state_next = ST_FINISH;
				end else begin
					state_next = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				cmd.align = 1'b1;
				if (!stat.align_more) begin
					state_next = ST_SUB;
				end
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				if (stat.k_zero) begin
					state_next = ST_SWAP;
				end
			end
			ST_SWAP: begin
				cmd.swap   = 1'b1;
				state_next = ST_CHECK;
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/rmi_datapath.sv
// remainder and coefficient registers with shift-subtract division steps
module rmi_datapath (
	input  logic                        clk,
	input  rmi_pkg::rmi_cmd_t           cmd,
	input  logic [rmi_pkg::VAL_W-1:0]   residue,
	input  logic [rmi_pkg::VAL_W-1:0]   modulus,
	output rmi_pkg::rmi_stat_t          stat,
	output logic [rmi_pkg::VAL_W-1:0]   inverse,
	output logic                        not_invertible
);

	logic [rmi_pkg::VAL_W-1:0]   r_q;
	logic [rmi_pkg::VAL_W-1:0]   r1_q;
	logic [rmi_pkg::COEF_W-1:0]  t_q;
	logic [rmi_pkg::COEF_W-1:0]  t1_q;
	logic [rmi_pkg::VAL_W:0]     d_q;
	logic [rmi_pkg::SHIFT_W-1:0] k_q;
	logic [rmi_pkg::VAL_W-1:0]   m_q;
	logic                        zero_q;

	logic [rmi_pkg::VAL_W+1:0]   d_dbl;
	logic                        d_fits;
	logic [rmi_pkg::COEF_W-1:0]  t1_shl;
	logic [rmi_pkg::COEF_W-1:0]  t_fold;

	assign d_dbl  = {d_q, 1'b0};
	assign d_fits = d_q <= {1'b0, r_q};
	assign t1_shl = t1_q << k_q;

	assign stat.r1_zero    = r1_q == '0;
	assign stat.align_more = d_dbl <= {2'b00, r_q};
	assign stat.k_zero     = k_q == '0;

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q    <= modulus;
			r1_q   <= residue;
			t_q    <= '0;
			t1_q   <= rmi_pkg::COEF_W'(1);
			m_q    <= modulus;
			zero_q <= residue == '0;
		end else if (cmd.check) begin
			d_q <= {1'b0, r1_q};
			k_q <= '0;
		end else if (cmd.align) begin
			if (stat.align_more) begin
				d_q <= d_dbl[rmi_pkg::VAL_W:0];
				k_q <= k_q + rmi_pkg::SHIFT_W'(1);
			end
		end else if (cmd.sub) begin
			if (d_fits) begin
				r_q <= r_q - d_q[rmi_pkg::VAL_W-1:0];
				t_q <= t_q - t1_shl;
			end
			if (!stat.k_zero) begin
				d_q <= d_q >> 1;
				k_q <= k_q - rmi_pkg::SHIFT_W'(1);
			end
		end else if (cmd.swap) begin
			r_q  <= r1_q;
			r1_q <= r_q;
			t_q  <= t1_q;
			t1_q <= t_q;
		end
	end

	// negative coefficient folds back by adding the modulus
	assign t_fold = t_q[rmi_pkg::COEF_W-1] ?
		t_q + {{(rmi_pkg::COEF_W-rmi_pkg::VAL_W){1'b0}}, m_q} : t_q;

	assign inverse        = zero_q ? '0 : t_fold[rmi_pkg::VAL_W-1:0];
	assign not_invertible = zero_q;

endmodule

### tb/sv/residue_modular_inverse_tb.sv
// self-checking testbench for residue_modular_inverse with predictor and scoreboard
module residue_modular_inverse_tb;

	localparam int NUM_MODULI = rmi_pkg::NUM_MODULI;
	localparam int VAL_W      = rmi_pkg::VAL_W;
	localparam int IDX_W      = rmi_pkg::IDX_W;
	localparam int DATA_W     = rmi_pkg::DATA_W;

	localparam logic [IDX_W-1:0] REG_MODULUS_0 = 2'd0;
	localparam logic [IDX_W-1:0] REG_MODULUS_1 = 2'd1;
	localparam logic [IDX_W-1:0] REG_MODULUS_2 = 2'd2;
	localparam logic [IDX_W-1:0] REG_MODULUS_3 = 2'd3;

	localparam logic [VAL_W-1:0] VAL_MAX    = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] PRIME_62   = 62'h3FFF_FFFF_FFFF_FFC7;
	localparam logic [VAL_W-1:0] PRIME_61   = 62'h1FFF_FFFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0] PRIME_1E9  = 62'd1000000007;

	localparam int IDLE_PCT    = 22;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_WAIT  = 600;

	typedef struct {
		logic [VAL_W-1:0] residue;
		logic [IDX_W-1:0] sel;
	} residue_item_t;

	typedef struct {
		logic [VAL_W-1:0] inverse;
		logic             not_invertible;
	} inverse_result_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [DATA_W-1:0]   s_axis_tdata  = '0;  // residue[61:0]
	logic [IDX_W-1:0]    s_axis_tuser  = '0;  // modulus_index[1:0]
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [DATA_W-1:0]   m_axis_tdata;        // inverse[61:0]
	logic                m_axis_tuser;        // not_invertible
	logic                wr_en         = 1'b0;
	logic [IDX_W-1:0]    wr_index      = '0;
	logic [VAL_W-1:0]    wr_data       = '0;

	residue_modular_inverse dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always #10 clk = ~clk;

	logic [VAL_W-1:0] modulus_cfg [NUM_MODULI];
	residue_item_t    residues_to_send [$];
	inverse_result_t  predicted_inverses [$];
	residue_item_t    next_item;
	inverse_result_t  want;

	int  residues_taken  = 0;
	int  zero_residues   = 0;
	int  results_checked = 0;
	int  mismatches      = 0;
	int  settings_used   = 0;
	int  idle_cycles     = 0;
	int  hold_left       = 0;
	bit  hold_done       = 1'b0;
	bit  in_fire         = 1'b0;
	bit  steady;

	assign steady = (residues_taken >= 300 && residues_taken < 420) || hold_left != 0;

	function automatic logic [VAL_W-1:0] rand_val();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[VAL_W-1:0];
	endfunction

	// extended euclid on (modulus, residue), coefficients in 64-bit two's complement
	function automatic inverse_result_t predict_inverse(logic [VAL_W-1:0] residue,
			logic [IDX_W-1:0] sel);
		inverse_result_t res;
		logic [63:0] m, t, t1, r, r1, q, nt, nr;
		int unsigned idx;
		idx = 32'(sel);
		if (idx >= NUM_MODULI)
			idx = 0;
		m = {2'b00, modulus_cfg[idx]};
		if (residue == '0) begin
			res.inverse = '0;
			res.not_invertible = 1'b1;
			return res;
		end
		t  = 64'd0;
		t1 = 64'd1;
		r  = m;
		r1 = {2'b00, residue};
		while (r1 != 64'd0) begin
			q  = r / r1;
			nt = t - q * t1;
			nr = r - q * r1;
			t  = t1;
			t1 = nt;
			r  = r1;
			r1 = nr;
		end
		if (t[63])
			t = t + m;
		res.inverse = t[VAL_W-1:0];
		res.not_invertible = 1'b0;
		return res;
	endfunction

	function automatic logic [VAL_W-1:0] table_modulus(int unsigned k);
		case (k)
			0:       return 62'd2;
			1:       return 62'd3;
			2:       return 62'd17;
			3:       return 62'd65537;
			4:       return 62'd2147483647;
			5:       return 62'd998244353;
			6:       return PRIME_1E9;
			7:       return PRIME_61;
			8:       return PRIME_62;
			9:       return VAL_MAX;
			default: return 62'd1000000000000;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_modulus();
		logic [VAL_W-1:0] v;
		if ($urandom_range(0, 99) < 20) begin
			v = rand_val() | 62'd1;
			return (v < 62'd2) ? 62'd3 : v;
		end
		return table_modulus($urandom_range(0, 10));
	endfunction

	// mostly reduced residues, with zeros, unreduced values and multiples mixed in
	function automatic logic [VAL_W-1:0] pick_residue(logic [VAL_W-1:0] m);
		int unsigned roll;
		logic [VAL_W-1:0] v;
		roll = $urandom_range(0, 99);
		v = rand_val();
		if (roll < 5)
			return '0;
		if (roll < 12)
			return v;
		if (roll < 15)
			return m * $urandom_range(1, 3);
		if (roll < 17)
			return 62'd1;
		if (roll < 19)
			return m - 62'd1;
		return v % m;
	endfunction

	task automatic write_modulus(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		modulus_cfg[idx] = value;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_moduli(logic [VAL_W-1:0] m0, logic [VAL_W-1:0] m1,
			logic [VAL_W-1:0] m2, logic [VAL_W-1:0] m3);
		write_modulus(REG_MODULUS_0, m0);
		write_modulus(REG_MODULUS_1, m1);
		write_modulus(REG_MODULUS_2, m2);
		write_modulus(REG_MODULUS_3, m3);
		settings_used++;
	endtask

	task automatic queue_residue(logic [VAL_W-1:0] residue, logic [IDX_W-1:0] sel);
		residue_item_t it;
		it.residue = residue;
		it.sel = sel;
		residues_to_send.push_back(it);
	endtask

	task automatic wait_drained();
		while (residues_to_send.size() != 0 || predicted_inverses.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// input driver
	always @(negedge clk) begin
		if (!s_axis_tvalid || in_fire) begin
			if (residues_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
				next_item = residues_to_send.pop_front();
				s_axis_tdata  <= {{(DATA_W-VAL_W){1'b0}}, next_item.residue};
				s_axis_tuser  <= next_item.sel;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output backpressure, with one long hold-off to fill the block
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && residues_taken >= 700) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		in_fire = s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			predicted_inverses.push_back(predict_inverse(s_axis_tdata[VAL_W-1:0], s_axis_tuser));
			residues_taken++;
			if (s_axis_tdata[VAL_W-1:0] == '0)
				zero_residues++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (predicted_inverses.size() == 0) begin
				mismatches++;
				if (mismatches <= 100)
					$display("%0t: unexpected word, expected none, got inverse %h flag %b",
						$time, m_axis_tdata[VAL_W-1:0], m_axis_tuser);
			end else begin
				want = predicted_inverses.pop_front();
				results_checked++;
				if (m_axis_tdata[VAL_W-1:0] !== want.inverse) begin
					mismatches++;
					if (mismatches <= 100)
						$display("%0t: inverse mismatch, expected %h, got %h",
							$time, want.inverse, m_axis_tdata[VAL_W-1:0]);
				end
				if (m_axis_tuser !== want.not_invertible) begin
					mismatches++;
					if (mismatches <= 100)
						$display("%0t: not_invertible mismatch, expected %b, got %b",
							$time, want.not_invertible, m_axis_tuser);
				end
			end
		end
	end

	// no handshake for too long means the block hung
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int ph;
		int n;
		logic [IDX_W-1:0] sel;
		for (int i = 0; i < NUM_MODULI; i++)
			modulus_cfg[i] = 62'd2;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset moduli
		queue_residue(62'd1, REG_MODULUS_0);
		queue_residue(62'd3, REG_MODULUS_1);
		queue_residue(62'd0, REG_MODULUS_2);
		queue_residue(VAL_MAX, REG_MODULUS_3);
		wait_drained();

		// directed: zeros, edges, unreduced values, multiples, shared factor
		set_moduli(PRIME_62, PRIME_61, PRIME_1E9, VAL_MAX);
		queue_residue(62'd0, REG_MODULUS_0);
		queue_residue(62'd0, REG_MODULUS_1);
		queue_residue(62'd0, REG_MODULUS_2);
		queue_residue(62'd0, REG_MODULUS_3);
		queue_residue(62'd1, REG_MODULUS_0);
		queue_residue(62'd1, REG_MODULUS_1);
		queue_residue(PRIME_62 - 62'd1, REG_MODULUS_0);
		queue_residue(PRIME_61 - 62'd1, REG_MODULUS_1);
		queue_residue(PRIME_1E9 - 62'd1, REG_MODULUS_2);
		queue_residue(VAL_MAX, REG_MODULUS_0);
		queue_residue(VAL_MAX, REG_MODULUS_3);
		queue_residue(PRIME_1E9 * 62'd3, REG_MODULUS_2);
		queue_residue(62'd3, REG_MODULUS_3);
		queue_residue(62'd2, REG_MODULUS_2);
		queue_residue(PRIME_1E9 + 62'd5, REG_MODULUS_2);
		queue_residue(62'd12345678901234567, REG_MODULUS_0);
		queue_residue(62'h2AAA_AAAA_AAAA_AAAA, REG_MODULUS_1);
		queue_residue(62'h1555_5555_5555_5555, REG_MODULUS_0);
		wait_drained();

		// random phases, first one at the register extremes
		for (ph = 0; ph < 6; ph++) begin
			if (ph == 0)
				set_moduli(62'd2, VAL_MAX, PRIME_62, 62'd3);
			else
				set_moduli(pick_modulus(), pick_modulus(), pick_modulus(), pick_modulus());
			for (n = 0; n < 195; n++) begin
				sel = IDX_W'($urandom_range(0, NUM_MODULI - 1));
				queue_residue(pick_residue(modulus_cfg[sel]), sel);
			end
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("run covered %0d residues (%0d zero) under %0d modulus settings, %0d checked",
			residues_taken, zero_residues, settings_used, results_checked);
		$display("one output hold-off of %0d cycles was applied, %0d mismatches seen",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0 && predicted_inverses.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
hdl/rmi_pkg.sv
hdl/rmi_ctrl.sv
hdl/rmi_datapath.sv
hdl/residue_modular_inverse.sv
tb/sv/residue_modular_inverse_tb.sv
